// File: hdl/assert_macros.svh
// assertion helpers shared by the block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define SRW_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define SRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/srw_pkg.sv
package srw_pkg;

  localparam int WINDOW    = 16;
  localparam int SEG_BYTES = 1000;

  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int LEN_W   = 10;
  localparam int SEG_W   = 24;
  localparam int BYTE_W  = 24;
  localparam int TIME_W  = 32;
  localparam int TMO_W   = 16;
  localparam int COPY_W  = 2;
  localparam int START_W = $clog2((longint'(2) ** SEG_W + longint'(WINDOW))
                                  * longint'(SEG_BYTES));

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [BYTE_W-1:0] TOTAL_RST   = '0;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = TMO_W'(100);
  localparam logic [COPY_W-1:0] COPIES_RST  = COPY_W'(1);

  localparam logic REQ_ACK  = 1'b0;
  localparam logic REQ_PASS = 1'b1;

  localparam logic KIND_REQ  = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [1:0] {
    REG_TOTAL_BYTES = 2'd0,
    REG_TIMEOUT_MS  = 2'd1,
    REG_COPIES      = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] total_bytes;
    logic [TMO_W-1:0]  timeout_ms;
    logic [COPY_W-1:0] copies;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic ack_chk;
    logic ack_set;
    logic retire;
    logic scan_init;
    logic stamp;
    logic next_slot;
    logic load_req;
    logic load_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic head_acked;
    logic slot_due;
    logic has_bytes;
    logic scan_last;
    logic copies_zero;
    logic copy_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: hdl/selective_repeat_request_window.sv
// Sender window for selective-repeat transfers over a ring of 16 segment slots.
// Input channel (in_valid_i/in_ready_o): an ack item (req_type 0) marks the
// slot of an absolute segment number; a pass item (req_type 1) retires acked
// slots at the head, then requests every due slot and ends with a done item.
// Output channel (out_valid_o/out_ready_i): request items carry start_byte and
// seg_length, each repeated 'copies' times; the done item has last set and
// delivered_bytes holds the running in-order byte total in every item.
// Configuration: APB registers total_bytes (0x0), timeout_ms (0x4), copies (0x8).
// Sequence: an ack is captured, checked against the window, then marked if it
// hits. A pass is captured, retires acked head slots one at a time, scans up
// to 16 slots, loads each request item and then the done item; the scan
// sequencer handles one item at a time and input is taken only when it is idle.
// A finished result sits in the output register, so the next item is accepted
// while the done item waits; a stalled receiver holds the scan in place.
// Reset clears all slots, the head and the totals; registers return to
// total_bytes 0, timeout_ms 100, copies 1.
module selective_repeat_request_window (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srw_pkg::ADDR_W-1:0]  paddr,
  input  logic [srw_pkg::DATA_W-1:0]  pwdata,
  output logic [srw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_req_type_i,
  input  logic [srw_pkg::SEG_W-1:0]   in_segment_number_i,
  input  logic [srw_pkg::TIME_W-1:0]  in_now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_kind_o,
  output logic [srw_pkg::BYTE_W-1:0]  out_start_byte_o,
  output logic [srw_pkg::LEN_W-1:0]   out_seg_length_o,
  output logic [srw_pkg::BYTE_W-1:0]  out_delivered_bytes_o,
  output logic                        out_last_o
);

  srw_pkg::cfg_t      cfg;
  srw_pkg::ctrl_cmd_t cmd;
  srw_pkg::ctrl_sts_t sts;

  srw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  srw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_req_type_i),
    .in_ready_o    (in_ready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  srw_dp u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .in_segment_number_i   (in_segment_number_i),
    .in_now_ms_i           (in_now_ms_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .out_kind_o            (out_kind_o),
    .out_start_byte_o      (out_start_byte_o),
    .out_seg_length_o      (out_seg_length_o),
    .out_delivered_bytes_o (out_delivered_bytes_o),
    .out_last_o            (out_last_o)
  );

endmodule

// File: hdl/srw_cfg.sv
module srw_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [srw_pkg::ADDR_W-1:0] paddr,
  input  logic [srw_pkg::DATA_W-1:0] pwdata,
  output logic [srw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output srw_pkg::cfg_t              cfg_o
);

  logic [srw_pkg::BYTE_W-1:0] total_q;
  logic [srw_pkg::TMO_W-1:0]  timeout_q;
  logic [srw_pkg::COPY_W-1:0] copies_q;
  srw_pkg::reg_idx_e          idx;
  logic                       wr_en;

  assign idx   = srw_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= srw_pkg::TOTAL_RST;
      timeout_q <= srw_pkg::TIMEOUT_RST;
      copies_q  <= srw_pkg::COPIES_RST;
    end else if (wr_en) begin
      unique case (idx)
        srw_pkg::REG_TOTAL_BYTES: total_q   <= pwdata[srw_pkg::BYTE_W-1:0];
        srw_pkg::REG_TIMEOUT_MS:  timeout_q <= pwdata[srw_pkg::TMO_W-1:0];
        srw_pkg::REG_COPIES:      copies_q  <= pwdata[srw_pkg::COPY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      srw_pkg::REG_TOTAL_BYTES: prdata = srw_pkg::DATA_W'(total_q);
      srw_pkg::REG_TIMEOUT_MS:  prdata = srw_pkg::DATA_W'(timeout_q);
      srw_pkg::REG_COPIES:      prdata = srw_pkg::DATA_W'(copies_q);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o.total_bytes = total_q;
  assign cfg_o.timeout_ms  = timeout_q;
  assign cfg_o.copies      = copies_q;

endmodule

// File: hdl/srw_ctrl.sv
module srw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_req_type_i,
  output logic                  in_ready_o,
  input  srw_pkg::ctrl_sts_t    sts_i,
  output srw_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_ACK_CHK = 7'b0000010,
    ST_ACK_SET = 7'b0000100,
    ST_ADV     = 7'b0001000,
    ST_SCAN    = 7'b0010000,
    ST_EMIT    = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = (in_req_type_i == srw_pkg::REQ_PASS) ? ST_ADV : ST_ACK_CHK;
        end
      end
      ST_ACK_CHK: begin
        cmd_o.ack_chk = 1'b1;
        state_d = ST_ACK_SET;
      end
      ST_ACK_SET: begin
        cmd_o.ack_set = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ADV: begin
        if (sts_i.head_acked) begin
          cmd_o.retire = 1'b1;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.slot_due && !sts_i.has_bytes) begin
          state_d = ST_DONE;
        end else if (sts_i.slot_due) begin
          cmd_o.stamp = 1'b1;
          if (!sts_i.copies_zero) begin
            state_d = ST_EMIT;
          end else if (sts_i.scan_last) begin
            state_d = ST_DONE;
          end else begin
            cmd_o.next_slot = 1'b1;
          end
        end else if (sts_i.scan_last) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.next_slot = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.copy_last) begin
            if (sts_i.scan_last) begin
              state_d = ST_DONE;
            end else begin
              cmd_o.next_slot = 1'b1;
              state_d = ST_SCAN;
            end
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_done = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/srw_dp.sv
`include "assert_macros.svh"

module srw_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  srw_pkg::cfg_t               cfg_i,
  input  srw_pkg::ctrl_cmd_t          cmd_i,
  output srw_pkg::ctrl_sts_t          sts_o,
  input  logic [srw_pkg::SEG_W-1:0]   in_segment_number_i,
  input  logic [srw_pkg::TIME_W-1:0]  in_now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        out_kind_o,
  output logic [srw_pkg::BYTE_W-1:0]  out_start_byte_o,
  output logic [srw_pkg::LEN_W-1:0]   out_seg_length_o,
  output logic [srw_pkg::BYTE_W-1:0]  out_delivered_bytes_o,
  output logic                        out_last_o
);

  localparam int SLOT_W  = srw_pkg::SLOT_W;
  localparam int START_W = srw_pkg::START_W;
  localparam int LEN_W   = srw_pkg::LEN_W;
  localparam int BYTE_W  = srw_pkg::BYTE_W;
  localparam int SEG_W   = srw_pkg::SEG_W;
  localparam int TIME_W  = srw_pkg::TIME_W;
  localparam int COPY_W  = srw_pkg::COPY_W;
  localparam int WIN     = srw_pkg::WINDOW;

  function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
                                                 logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] sum;
    sum = (SLOT_W+1)'(a) + (SLOT_W+1)'(b);
    if (sum >= (SLOT_W+1)'(WIN)) begin
      sum = sum - (SLOT_W+1)'(WIN);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] seg_len(logic [START_W-1:0] start,
                                               logic [BYTE_W-1:0]  total);
    logic [START_W-1:0] rem;
    logic [LEN_W-1:0]   len;
    rem = START_W'(total) - start;
    if (start >= START_W'(total)) begin
      len = '0;
    end else if (rem < START_W'(srw_pkg::SEG_BYTES)) begin
      len = rem[LEN_W-1:0];
    end else begin
      len = LEN_W'(srw_pkg::SEG_BYTES);
    end
    return len;
  endfunction

  logic [SEG_W-1:0]   segno_q;
  logic [TIME_W-1:0]  now_q;
  logic [WIN-1:0]     acked_q;
  logic [WIN-1:0]     sent_q;
  logic [TIME_W-1:0]  time_q [WIN];
  logic [SLOT_W-1:0]  head_q;
  logic [SEG_W-1:0]   segs_q;
  logic [START_W-1:0] head_start_q;
  logic [BYTE_W-1:0]  bytes_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [START_W-1:0] scan_start_q;
  logic [COPY_W-1:0]  copy_q;
  logic [SLOT_W-1:0]  off_q;
  logic               ack_ok_q;

  logic               out_valid_q;
  logic               out_kind_q;
  logic [BYTE_W-1:0]  out_start_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [BYTE_W-1:0]  out_deliv_q;
  logic               out_last_q;

  logic [SLOT_W-1:0]  cur_slot;
  logic [SLOT_W-1:0]  ack_slot;
  logic [SEG_W-1:0]   ack_diff;
  logic [START_W-1:0] ack_start;
  logic               ack_hit;
  logic [TIME_W-1:0]  age;
  logic [LEN_W-1:0]   head_len;
  logic [LEN_W-1:0]   scan_len;
  logic [BYTE_W:0]    bytes_sum;
  logic               out_free;

  assign cur_slot  = slot_add(head_q, idx_q);
  assign ack_slot  = slot_add(head_q, off_q);
  assign ack_diff  = segno_q - segs_q;
  assign ack_start = head_start_q + START_W'(off_q) * START_W'(srw_pkg::SEG_BYTES);
  assign ack_hit   = ack_ok_q && (ack_start < START_W'(cfg_i.total_bytes));
  assign age       = now_q - time_q[cur_slot];
  assign head_len  = seg_len(head_start_q, cfg_i.total_bytes);
  assign scan_len  = seg_len(scan_start_q, cfg_i.total_bytes);
  assign bytes_sum = (BYTE_W+1)'(bytes_q) + (BYTE_W+1)'(head_len);
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.head_acked  = acked_q[head_q];
  assign sts_o.slot_due    = !acked_q[cur_slot] &&
                             (!sent_q[cur_slot] || age >= TIME_W'(cfg_i.timeout_ms));
  assign sts_o.has_bytes   = scan_start_q < START_W'(cfg_i.total_bytes);
  assign sts_o.scan_last   = (idx_q == SLOT_W'(WIN - 1));
  assign sts_o.copies_zero = (cfg_i.copies == '0);
  assign sts_o.copy_last   = (copy_q == COPY_W'(1));
  assign sts_o.out_free    = out_free;

  // captured item fields, ack slot offset and slot send times
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      segno_q <= in_segment_number_i;
      now_q   <= in_now_ms_i;
    end
    if (cmd_i.ack_chk) begin
      off_q <= ack_diff[SLOT_W-1:0];
    end
    if (cmd_i.stamp) begin
      time_q[cur_slot] <= now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_ok_q <= 1'b0;
    end else if (cmd_i.ack_chk) begin
      ack_ok_q <= (segno_q >= segs_q) && (ack_diff < SEG_W'(WIN));
    end
  end

  // slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q <= '0;
      sent_q  <= '0;
    end else begin
      if (cmd_i.retire) begin
        acked_q[head_q] <= 1'b0;
        sent_q[head_q]  <= 1'b0;
      end
      if (cmd_i.ack_set && ack_hit) begin
        acked_q[ack_slot] <= 1'b1;
      end
      if (cmd_i.stamp) begin
        sent_q[cur_slot] <= 1'b1;
      end
    end
  end

  // window head and delivered totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      segs_q       <= '0;
      head_start_q <= '0;
      bytes_q      <= '0;
    end else if (cmd_i.retire) begin
      head_q       <= slot_add(head_q, SLOT_W'(1));
      segs_q       <= segs_q + SEG_W'(1);
      head_start_q <= (segs_q == '1) ? '0 :
                      head_start_q + START_W'(srw_pkg::SEG_BYTES);
      bytes_q      <= bytes_sum[BYTE_W] ? '1 : bytes_sum[BYTE_W-1:0];
    end
  end

  // scan cursor and copy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      scan_start_q <= '0;
      copy_q       <= '0;
    end else begin
      if (cmd_i.scan_init) begin
        idx_q        <= '0;
        scan_start_q <= head_start_q;
      end else if (cmd_i.next_slot) begin
        idx_q        <= idx_q + SLOT_W'(1);
        scan_start_q <= scan_start_q + START_W'(srw_pkg::SEG_BYTES);
      end
      if (cmd_i.stamp) begin
        copy_q <= cfg_i.copies;
      end else if (cmd_i.load_req) begin
        copy_q <= copy_q - COPY_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_req || cmd_i.load_done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      out_kind_q  <= srw_pkg::KIND_REQ;
      out_start_q <= scan_start_q[BYTE_W-1:0];
      out_len_q   <= scan_len;
      out_deliv_q <= bytes_q;
      out_last_q  <= 1'b0;
    end else if (cmd_i.load_done) begin
      out_kind_q  <= srw_pkg::KIND_DONE;
      out_start_q <= '0;
      out_len_q   <= '0;
      out_deliv_q <= bytes_q;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_kind_o            = out_kind_q;
  assign out_start_byte_o      = out_start_q;
  assign out_seg_length_o      = out_len_q;
  assign out_delivered_bytes_o = out_deliv_q;
  assign out_last_o            = out_last_q;

  `SRW_ASSERT(a_load_excl, !(cmd_i.load_req && cmd_i.load_done), "request and done loaded together")
  `SRW_ASSERT(a_load_free, !(cmd_i.load_req || cmd_i.load_done) || out_free, "output overwritten")
  `SRW_ASSERT(a_retire_acked, !cmd_i.retire || acked_q[head_q], "retired an unacked slot")
  `SRW_ASSERT(a_stamp_unacked, !cmd_i.stamp || !acked_q[cur_slot], "stamped an acked slot")
  `SRW_ASSERT_NEXT(a_bytes_mono, cmd_i.retire, bytes_q >= $past(bytes_q), "byte total fell")

endmodule
